@@ src/salc_pkg.sv @@
// ----------------------------------------------------------------------------
// salc_pkg
// shared constants for the set-associative lru cache tag store
// ----------------------------------------------------------------------------
package salc_pkg;

  // default sizing
  localparam int SET_BITS_MAX_DEF = 6;
  localparam int WAYS_MAX_DEF     = 8;
  localparam int TOTAL_WIDTH_DEF  = 32;

  // fixed field widths
  localparam int ADDR_W    = 64;
  localparam int OP_W      = 2;
  localparam int OUT_CNT_W = 32;
  localparam int IN_DATA_W = 64;
  localparam int OUT_DATA_W = 104;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;
  localparam logic [CFG_IDX_W-1:0] REG_SET_BITS  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WAYS      = 2'd2;
  localparam logic [2:0] SET_BITS_RST = 3'd4;
  localparam logic [5:0] OFF_BITS_RST = 6'd4;
  localparam logic [3:0] WAYS_RST     = 4'd8;

  // access kinds
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
  localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
  localparam logic [OP_W-1:0] OP_IFETCH = 2'd3;

endpackage

@@ src/set_assoc_lru_cache_tags.sv @@
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_tags
// tag store of a set-associative cache with lru replacement and hit, miss
// and eviction totals
// ----------------------------------------------------------------------------
// channel | dir | handshake                  | payload
// in      | in  | in_tvalid / in_tready      | in_tuser operation, in_tdata address
// out     | out | out_tvalid / out_tready    | out_tdata flags and totals
// cfg     | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// in the accept cycle an item reads the set row from the tag and age memories;
// the lookup state then compares, writes the row back unless the access is an
// instruction fetch, and loads the output register.
// a stalled result holds the lookup state until the output register frees.
// reset clears one written bit per set row; no clearing pass is run.
// cfg_ready is always high.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_tags #(
  parameter int SET_BITS_MAX = salc_pkg::SET_BITS_MAX_DEF,
  parameter int WAYS_MAX     = salc_pkg::WAYS_MAX_DEF,
  parameter int TOTAL_WIDTH  = salc_pkg::TOTAL_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [salc_pkg::IN_DATA_W-1:0]      in_tdata,   // address
  input  logic [salc_pkg::OP_W-1:0]           in_tuser,   // operation
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // hit, miss, evicted, hit_total, miss_total, eviction_total, zero pad
  output logic [salc_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [salc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [salc_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int NUM_SETS = 1 << SET_BITS_MAX;
  localparam int SET_W    = (SET_BITS_MAX > 0) ? SET_BITS_MAX : 1;
  localparam int SET_CAP  = (SET_BITS_MAX > 7) ? 7 : SET_BITS_MAX;
  localparam int AGE_W    = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int WAY_W    = (WAYS_MAX > 1) ? $clog2(WAYS_MAX) : 1;
  localparam int ADDR_W   = salc_pkg::ADDR_W;
  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS_MAX - 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_LOOK = 1'b1;

  typedef struct packed {
    logic [AGE_W-1:0] age;
    logic             valid;
  } meta_t;

  typedef meta_t [WAYS_MAX-1:0]             meta_row_t;
  typedef logic [WAYS_MAX-1:0][ADDR_W-1:0]  tag_row_t;

  // configuration
  logic [2:0] cfg_set_bits_r;
  logic [5:0] cfg_off_bits_r;
  logic [3:0] cfg_ways_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_set_bits_r <= salc_pkg::SET_BITS_RST;
      cfg_off_bits_r <= salc_pkg::OFF_BITS_RST;
      cfg_ways_r     <= salc_pkg::WAYS_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        salc_pkg::REG_SET_BITS: cfg_set_bits_r <= cfg_data[2:0];
        salc_pkg::REG_OFF_BITS: cfg_off_bits_r <= cfg_data[5:0];
        salc_pkg::REG_WAYS:     cfg_ways_r     <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // control
  logic state_r, state_nxt;
  logic out_free;
  logic rd_en;
  logic wr_en;
  logic out_tvalid_r;

  assign in_tready = (state_r == ST_IDLE);
  assign rd_en     = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;
  assign out_tvalid = out_tvalid_r;

  // address split
  logic [2:0]        s_eff;
  logic [6:0]        tshift;
  logic [ADDR_W-1:0] addr_sh;
  logic [SET_W-1:0]  set_keep;
  logic [SET_W-1:0]  set_in;
  logic [ADDR_W-1:0] tag_in;

  always_comb begin
    s_eff    = (cfg_set_bits_r > 3'(SET_CAP)) ? 3'(SET_CAP) : cfg_set_bits_r;
    tshift   = {1'b0, cfg_off_bits_r} + {4'd0, s_eff};
    addr_sh  = in_tdata >> cfg_off_bits_r;
    set_keep = ~({SET_W{1'b1}} << s_eff);
    set_in   = addr_sh[SET_W-1:0] & set_keep;
    tag_in   = (tshift >= 7'd64) ? '0 : (in_tdata >> tshift[5:0]);
  end

  logic [salc_pkg::OP_W-1:0] op_r;
  logic [SET_W-1:0]          set_r;
  logic [ADDR_W-1:0]         tag_r;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      op_r  <= in_tuser;
      set_r <= set_in;
      tag_r <= tag_in;
    end
  end

  // memories
  tag_row_t  tag_mem  [NUM_SETS];
  meta_row_t meta_mem [NUM_SETS];
  tag_row_t  tag_rd_r;
  meta_row_t meta_rd_r;
  tag_row_t  tag_wr;
  meta_row_t meta_wr;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      tag_rd_r  <= tag_mem[set_in];
      meta_rd_r <= meta_mem[set_in];
    end
    if (wr_en) begin
      tag_mem[set_r]  <= tag_wr;
      meta_mem[set_r] <= meta_wr;
    end
  end

  logic [NUM_SETS-1:0] row_written_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_written_r <= '0;
    end else if (wr_en) begin
      row_written_r[set_r] <= 1'b1;
    end
  end

  // lookup and replacement
  logic [4:0]          ways_eff;
  logic [WAYS_MAX-1:0] use_way;
  meta_row_t           meta_cur;
  logic [WAYS_MAX-1:0] match;
  logic                found;
  logic [WAY_W-1:0]    hit_way;
  logic                empty;
  logic [WAY_W-1:0]    inv_way;
  logic                have_best;
  logic [AGE_W-1:0]    best_age;
  logic [WAY_W-1:0]    vic_way;
  logic [WAY_W-1:0]    target;
  logic [AGE_W-1:0]    hage;
  logic                active;

  always_comb begin
    if (cfg_ways_r == 4'd0) begin
      ways_eff = 5'd1;
    end else if ({1'b0, cfg_ways_r} > 5'(WAYS_MAX)) begin
      ways_eff = 5'(WAYS_MAX);
    end else begin
      ways_eff = {1'b0, cfg_ways_r};
    end
    meta_cur = row_written_r[set_r] ? meta_rd_r : '0;
    for (int w = 0; w < WAYS_MAX; w++) begin
      use_way[w] = 5'(w) < ways_eff;
      match[w]   = use_way[w] && meta_cur[w].valid && (tag_rd_r[w] == tag_r);
    end
    found   = 1'b0;
    hit_way = '0;
    empty   = 1'b0;
    inv_way = '0;
    for (int w = WAYS_MAX - 1; w >= 0; w--) begin
      if (match[w]) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (use_way[w] && !meta_cur[w].valid) begin
        empty   = 1'b1;
        inv_way = WAY_W'(w);
      end
    end
    have_best = 1'b0;
    best_age  = '0;
    vic_way   = '0;
    for (int w = 0; w < WAYS_MAX; w++) begin
      if (use_way[w] && (!have_best || meta_cur[w].age > best_age)) begin
        have_best = 1'b1;
        best_age  = meta_cur[w].age;
        vic_way   = WAY_W'(w);
      end
    end
    target = found ? hit_way : (empty ? inv_way : vic_way);
    hage   = meta_cur[hit_way].age;
    active = (op_r != salc_pkg::OP_IFETCH);

    meta_wr = meta_cur;
    tag_wr  = tag_rd_r;
    for (int w = 0; w < WAYS_MAX; w++) begin
      if (use_way[w]) begin
        if (WAY_W'(w) == target) begin
          meta_wr[w].valid = 1'b1;
          meta_wr[w].age   = '0;
          if (!found) begin
            tag_wr[w] = tag_r;
          end
        end else if (meta_cur[w].valid && meta_cur[w].age < AGE_MAX &&
                     (!found || meta_cur[w].age < hage)) begin
          meta_wr[w].age = meta_cur[w].age + AGE_W'(1);
        end
      end
    end
  end

  assign wr_en = (state_r == ST_LOOK) && out_free && active;

  // totals
  logic [TOTAL_WIDTH-1:0] hits_r, misses_r, evicts_r;
  logic [TOTAL_WIDTH-1:0] hits_one, hits_nxt, misses_nxt, evicts_nxt;
  logic                   hit_f, miss_f, ev_f;
  logic [63:0]            hits_ext, misses_ext, evicts_ext;

  always_comb begin
    hit_f  = active && found;
    miss_f = active && !found;
    ev_f   = miss_f && !empty;
    hits_one   = (hit_f && hits_r != '1) ? hits_r + TOTAL_WIDTH'(1) : hits_r;
    hits_nxt   = (active && op_r == salc_pkg::OP_MODIFY && hits_one != '1) ?
                 hits_one + TOTAL_WIDTH'(1) : hits_one;
    misses_nxt = (miss_f && misses_r != '1) ? misses_r + TOTAL_WIDTH'(1) : misses_r;
    evicts_nxt = (ev_f && evicts_r != '1) ? evicts_r + TOTAL_WIDTH'(1) : evicts_r;
    hits_ext   = 64'(hits_nxt);
    misses_ext = 64'(misses_nxt);
    evicts_ext = 64'(evicts_nxt);
  end

  logic [salc_pkg::OUT_DATA_W-1:0] out_tdata_r;
  assign out_tdata = out_tdata_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (rd_en) state_nxt = ST_LOOK;
      ST_LOOK: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
      hits_r       <= '0;
      misses_r     <= '0;
      evicts_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_LOOK && out_free) begin
        out_tvalid_r <= 1'b1;
        hits_r       <= hits_nxt;
        misses_r     <= misses_nxt;
        evicts_r     <= evicts_nxt;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_LOOK && out_free) begin
      out_tdata_r <= {5'd0, evicts_ext[31:0], misses_ext[31:0], hits_ext[31:0],
                      ev_f, miss_f, hit_f};
    end
  end

  a_no_accept_in_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LOOK |-> !in_tready)
    else $error("input accepted during lookup");

  a_result_from_lookup: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == ST_LOOK))
    else $error("result raised outside lookup");

  a_hit_miss_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[0] && out_tdata[1]))
    else $error("hit and miss both set");

  a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[2]) |-> out_tdata[1])
    else $error("eviction without miss");

  a_write_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> state_r == ST_IDLE)
    else $error("write-back did not end the item");

endmodule
